FILE: rtl/bba_pkg.sv
// Shared widths, status codes and interface structs of the buddy block allocator.
package bba_pkg;

    localparam int REQ_W  = 24;
    localparam int OFS_W  = 22;
    localparam int BLK_W  = 16;
    localparam int BYT_W  = 23;
    localparam int ST_W   = 2;
    localparam int AO_W   = 5;
    localparam int WORD_W = 32;
    localparam int WSEL   = 5;

    localparam logic [ST_W-1:0] ST_OK       = 2'd0;
    localparam logic [ST_W-1:0] ST_NO_FIT   = 2'd1;
    localparam logic [ST_W-1:0] ST_BAD_REQ  = 2'd2;
    localparam logic [ST_W-1:0] ST_BAD_FREE = 2'd3;

    localparam logic CMD_ALLOC = 1'b0;
    localparam logic CMD_FREE  = 1'b1;

    typedef struct packed {
        logic             start;
        logic [OFS_W-1:0] dividend;
    } div_req_t;

    typedef struct packed {
        logic             done;
        logic             rem_zero;
        logic [OFS_W-1:0] quot;
    } div_rsp_t;

endpackage

FILE: rtl/bba_if.sv
// Request and response channel interfaces of the buddy block allocator.
interface bba_req_if;
    logic                      valid;
    logic                      ready;
    logic                      cmd;
    logic [bba_pkg::REQ_W-1:0] req_bytes;
    logic [bba_pkg::OFS_W-1:0] user_offset;

    modport source (output valid, output cmd, output req_bytes, output user_offset,
                    input ready);
    modport sink   (input valid, input cmd, input req_bytes, input user_offset,
                    output ready);
endinterface

interface bba_rsp_if;
    logic                      valid;
    logic                      ready;
    logic [bba_pkg::ST_W-1:0]  status;
    logic [bba_pkg::OFS_W-1:0] payload_offset;
    logic [bba_pkg::BLK_W-1:0] used_blocks;
    logic [bba_pkg::BYT_W-1:0] used_bytes;

    modport source (output valid, output status, output payload_offset,
                    output used_blocks, output used_bytes, input ready);
    modport sink   (input valid, input status, input payload_offset,
                    input used_blocks, input used_bytes, output ready);
endinterface

FILE: rtl/bba_div.sv
// Offset splitter: arena offset to minimum-block unit and remainder check, registered.
module bba_div #(
    parameter int DIVISOR = 128
) (
    input  logic              clk,
    input  logic              rst_n,
    input  bba_pkg::div_req_t req,
    output bba_pkg::div_rsp_t rsp
);

    localparam int W  = bba_pkg::OFS_W;
    // block sizes are powers of two, so the divide is a shift and a mask
    localparam int SH = $clog2(DIVISOR);

    logic         done_reg, done_next;
    logic         rz_reg, rz_next;
    logic [W-1:0] q_reg, q_next;

    always_comb
    begin
        done_next = req.start;
        q_next    = q_reg;
        rz_next   = rz_reg;
        if (req.start)
        begin
            q_next  = req.dividend >> SH;
            rz_next = (req.dividend[SH-1:0] == '0);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            done_reg <= 1'b0;
        else
            done_reg <= done_next;
    end

    always_ff @(posedge clk)
    begin
        q_reg  <= q_next;
        rz_reg <= rz_next;
    end

    assign rsp.done     = done_reg;
    assign rsp.rem_zero = rz_reg;
    assign rsp.quot     = q_reg;

endmodule

FILE: rtl/buddy_block_allocator.sv
// Buddy block allocator: free bitmap and block order memories under one sequencer.
//
// Channel  Dir  Beat
// req      in   cmd, req_bytes, user_offset
// rsp      out  status, payload_offset, used_blocks, used_bytes
//
// Allocate: walks up from the needed order to one with a free block, scans its bitmap
// words and splits down again, bound by the single bitmap memory port used for scan
// and read-modify-write. Free: splits the offset, reads and checks the block order,
// reads the buddy per merge step, then sets the free bit. After reset a clearing pass
// over both memories runs while req.ready stays low. A result waits in the rsp
// register; a new beat is taken while it waits.
module buddy_block_allocator #(
    parameter int ORDER_COUNT     = 11,
    parameter int TOP_BLOCKS      = 32,
    parameter int MIN_BLOCK_BYTES = 128,
    parameter int HEADER_BYTES    = 64
) (
    input logic     clk,
    input logic     rst_n,
    bba_req_if.sink   req,
    bba_rsp_if.source rsp
);

    localparam int WORD_W     = bba_pkg::WORD_W;
    localparam int WSEL       = bba_pkg::WSEL;
    localparam int OFS_W      = bba_pkg::OFS_W;
    localparam int BLK_W      = bba_pkg::BLK_W;
    localparam int BYT_W      = bba_pkg::BYT_W;
    localparam int AO_W       = bba_pkg::AO_W;
    localparam int TOP_ORDER  = ORDER_COUNT - 1;
    localparam int UNIT_COUNT = TOP_BLOCKS << TOP_ORDER;
    localparam int UNIT_W     = $clog2(UNIT_COUNT);
    localparam int CNT_W      = UNIT_W + 1;
    localparam int OW         = $clog2(ORDER_COUNT);
    localparam int IW         = (UNIT_W > WSEL) ? UNIT_W : WSEL + 1;
    localparam int SZB        = $clog2(MIN_BLOCK_BYTES) + ORDER_COUNT;
    localparam int SZ_W       = ((SZB > bba_pkg::REQ_W) ? SZB : bba_pkg::REQ_W) + 1;
    localparam int MUL_W      = UNIT_W + $clog2(MIN_BLOCK_BYTES + 1) + 1;

    function automatic int word_base(int k);
        int b;
        b = 0;
        for (int j = 0; j < k; j++)
            b += ((UNIT_COUNT >> j) + WORD_W - 1) >> WSEL;
        return b;
    endfunction

    localparam int MAP_WORDS = word_base(ORDER_COUNT);
    localparam int MW_W      = $clog2(MAP_WORDS);
    localparam int TOP_WBASE = word_base(TOP_ORDER);
    localparam int CLR_LEN   = (MAP_WORDS > UNIT_COUNT) ? MAP_WORDS : UNIT_COUNT;
    localparam int CLR_W     = $clog2(CLR_LEN + 1);

    localparam logic [4:0] S_CLEAR  = 5'd0;
    localparam logic [4:0] S_IDLE   = 5'd1;
    localparam logic [4:0] S_A_ORD  = 5'd2;
    localparam logic [4:0] S_A_RD   = 5'd3;
    localparam logic [4:0] S_A_CHK  = 5'd4;
    localparam logic [4:0] S_A_SPL  = 5'd5;
    localparam logic [4:0] S_A_SRD  = 5'd6;
    localparam logic [4:0] S_A_SWR  = 5'd7;
    localparam logic [4:0] S_A_FIN  = 5'd8;
    localparam logic [4:0] S_F_DIV  = 5'd9;
    localparam logic [4:0] S_F_RD   = 5'd10;
    localparam logic [4:0] S_F_CHK  = 5'd11;
    localparam logic [4:0] S_F_BUD  = 5'd12;
    localparam logic [4:0] S_F_BCHK = 5'd13;
    localparam logic [4:0] S_F_SRD  = 5'd14;
    localparam logic [4:0] S_F_SWR  = 5'd15;
    localparam logic [4:0] S_DONE   = 5'd16;

    logic [4:0]              state_reg, state_next;
    logic [CLR_W-1:0]        clr_reg, clr_next;
    logic [OW-1:0]           order_reg, order_next;
    logic [OW-1:0]           need_reg, need_next;
    logic [IW-1:0]           idx_reg, idx_next;
    logic [MW_W-1:0]         waddr_reg, waddr_next;
    logic [UNIT_W-1:0]       unit_reg, unit_next;
    logic [bba_pkg::ST_W-1:0] st_reg, st_next;
    logic [OFS_W-1:0]        pay_reg, pay_next;
    logic [BLK_W-1:0]        blk_reg, blk_next;
    logic [BYT_W-1:0]        byt_reg, byt_next;
    logic [CNT_W-1:0]        cnt_reg [ORDER_COUNT];
    logic [CNT_W-1:0]        cnt_next [ORDER_COUNT];

    logic                    rsp_valid_reg, rsp_valid_next;
    logic [bba_pkg::ST_W-1:0] rsp_status_reg, rsp_status_next;
    logic [OFS_W-1:0]        rsp_pay_reg, rsp_pay_next;
    logic [BLK_W-1:0]        rsp_blk_reg, rsp_blk_next;
    logic [BYT_W-1:0]        rsp_byt_reg, rsp_byt_next;

    logic [WORD_W-1:0]       map_mem [MAP_WORDS];
    logic                    map_we, map_re;
    logic [MW_W-1:0]         map_waddr, map_raddr;
    logic [WORD_W-1:0]       map_wdata, map_rdata;

    logic [AO_W-1:0]         ao_mem [UNIT_COUNT];
    logic                    ao_we, ao_re;
    logic [UNIT_W-1:0]       ao_waddr, ao_raddr;
    logic [AO_W-1:0]         ao_wdata, ao_rdata;

    bba_pkg::div_req_t       div_req;
    bba_pkg::div_rsp_t       div_rsp;

    logic [MW_W-1:0]         wbase [ORDER_COUNT];
    logic [MW_W-1:0]         wb_cur;
    logic [IW-1:0]           bud_idx, sib_idx;
    logic [WSEL-1:0]         fb;
    logic [MW_W-1:0]         rel;
    logic [MW_W+WSEL-1:0]    idx_full;
    logic [SZ_W-1:0]         req_sum;
    logic [ORDER_COUNT-1:0]  fits_vec;
    logic [OW-1:0]           need_c;
    logic [SZ_W-1:0]         blk_bytes;
    logic [AO_W-1:0]         ao_k;
    logic [UNIT_W-1:0]       unit_c;
    logic [MUL_W-1:0]        pay_c;
    logic [WORD_W-1:0]       init_word;

    for (genvar k = 0; k < ORDER_COUNT; k++)
    begin : g_base
        assign wbase[k] = MW_W'(word_base(k));
    end

    bba_div #(
        .DIVISOR(MIN_BLOCK_BYTES)
    ) u_div (
        .clk  (clk),
        .rst_n(rst_n),
        .req  (div_req),
        .rsp  (div_rsp)
    );

    // smallest order whose payload holds the request
    always_comb
    begin
        req_sum = SZ_W'(req.req_bytes) + SZ_W'(HEADER_BYTES);
        need_c  = '0;
        for (int k = 0; k < ORDER_COUNT; k++)
            fits_vec[k] = req_sum <= (SZ_W'(MIN_BLOCK_BYTES) << k);
        for (int k = ORDER_COUNT - 1; k >= 0; k--)
            if (fits_vec[k])
                need_c = OW'(k);
    end

    always_comb
    begin
        fb = '0;
        for (int b = WORD_W - 1; b >= 0; b--)
            if (map_rdata[b])
                fb = WSEL'(b);
    end

    always_comb
    begin
        for (int b = 0; b < WORD_W; b++)
            init_word[b] = (int'(clr_reg) >= TOP_WBASE) &&
                           (((int'(clr_reg) - TOP_WBASE) << WSEL) + b < TOP_BLOCKS);
    end

    assign wb_cur    = wbase[order_reg];
    assign bud_idx   = idx_reg ^ IW'(1);
    assign sib_idx   = idx_reg | IW'(1);
    assign rel       = waddr_reg - wb_cur;
    assign idx_full  = {rel, fb};
    assign blk_bytes = (SZ_W'(MIN_BLOCK_BYTES) << order_reg) - SZ_W'(HEADER_BYTES);
    assign ao_k      = ao_rdata - AO_W'(1);
    assign unit_c    = UNIT_W'(idx_reg << order_reg);
    assign pay_c     = MUL_W'(unit_c) * MUL_W'(MIN_BLOCK_BYTES) + MUL_W'(HEADER_BYTES);

    always_comb
    begin
        state_next      = state_reg;
        clr_next        = clr_reg;
        order_next      = order_reg;
        need_next       = need_reg;
        idx_next        = idx_reg;
        waddr_next      = waddr_reg;
        unit_next       = unit_reg;
        st_next         = st_reg;
        pay_next        = pay_reg;
        blk_next        = blk_reg;
        byt_next        = byt_reg;
        cnt_next        = cnt_reg;
        rsp_valid_next  = rsp_valid_reg && !rsp.ready;
        rsp_status_next = rsp_status_reg;
        rsp_pay_next    = rsp_pay_reg;
        rsp_blk_next    = rsp_blk_reg;
        rsp_byt_next    = rsp_byt_reg;
        map_we          = 1'b0;
        map_re          = 1'b0;
        map_waddr       = '0;
        map_raddr       = '0;
        map_wdata       = '0;
        ao_we           = 1'b0;
        ao_re           = 1'b0;
        ao_waddr        = '0;
        ao_raddr        = '0;
        ao_wdata        = '0;
        div_req.start    = 1'b0;
        div_req.dividend = req.user_offset - OFS_W'(HEADER_BYTES);

        unique case (state_reg)
            S_CLEAR:
            begin
                if (int'(clr_reg) < MAP_WORDS)
                begin
                    map_we    = 1'b1;
                    map_waddr = MW_W'(clr_reg);
                    map_wdata = init_word;
                end
                if (int'(clr_reg) < UNIT_COUNT)
                begin
                    ao_we    = 1'b1;
                    ao_waddr = UNIT_W'(clr_reg);
                end
                clr_next = clr_reg + CLR_W'(1);
                if (int'(clr_reg) == CLR_LEN - 1)
                    state_next = S_IDLE;
            end
            S_IDLE:
            begin
                if (req.valid)
                begin
                    pay_next = '0;
                    if (req.cmd == bba_pkg::CMD_ALLOC)
                    begin
                        if (req.req_bytes == '0 || !fits_vec[TOP_ORDER])
                        begin
                            st_next    = bba_pkg::ST_BAD_REQ;
                            state_next = S_DONE;
                        end
                        else
                        begin
                            order_next = need_c;
                            need_next  = need_c;
                            state_next = S_A_ORD;
                        end
                    end
                    else if (req.user_offset < OFS_W'(HEADER_BYTES))
                    begin
                        st_next    = bba_pkg::ST_BAD_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        div_req.start = 1'b1;
                        state_next    = S_F_DIV;
                    end
                end
            end
            S_A_ORD:
            begin
                // skip orders with no free block
                if (cnt_reg[order_reg] != '0)
                begin
                    waddr_next = wb_cur;
                    state_next = S_A_RD;
                end
                else if (order_reg == OW'(TOP_ORDER))
                begin
                    st_next    = bba_pkg::ST_NO_FIT;
                    state_next = S_DONE;
                end
                else
                    order_next = order_reg + OW'(1);
            end
            S_A_RD:
            begin
                map_re     = 1'b1;
                map_raddr  = waddr_reg;
                state_next = S_A_CHK;
            end
            S_A_CHK:
            begin
                if (map_rdata == '0)
                begin
                    waddr_next = waddr_reg + MW_W'(1);
                    state_next = S_A_RD;
                end
                else
                begin
                    map_we    = 1'b1;
                    map_waddr = waddr_reg;
                    map_wdata = map_rdata & ~(WORD_W'(1) << fb);
                    cnt_next[order_reg] = cnt_reg[order_reg] - CNT_W'(1);
                    idx_next  = IW'(idx_full);
                    state_next = (order_reg > need_reg) ? S_A_SPL : S_A_FIN;
                end
            end
            S_A_SPL:
            begin
                order_next = order_reg - OW'(1);
                idx_next   = idx_reg << 1;
                state_next = S_A_SRD;
            end
            S_A_SRD:
            begin
                map_re     = 1'b1;
                map_raddr  = wb_cur + MW_W'(sib_idx >> WSEL);
                state_next = S_A_SWR;
            end
            S_A_SWR:
            begin
                // upper half becomes free
                map_we    = 1'b1;
                map_waddr = wb_cur + MW_W'(sib_idx >> WSEL);
                map_wdata = map_rdata | (WORD_W'(1) << sib_idx[WSEL-1:0]);
                cnt_next[order_reg] = cnt_reg[order_reg] + CNT_W'(1);
                state_next = (order_reg > need_reg) ? S_A_SPL : S_A_FIN;
            end
            S_A_FIN:
            begin
                ao_we      = 1'b1;
                ao_waddr   = unit_c;
                ao_wdata   = AO_W'(order_reg) + AO_W'(1);
                blk_next   = blk_reg + BLK_W'(1);
                byt_next   = byt_reg + BYT_W'(blk_bytes);
                pay_next   = OFS_W'(pay_c);
                st_next    = bba_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_F_DIV:
            begin
                if (div_rsp.done)
                begin
                    if (!div_rsp.rem_zero || int'(div_rsp.quot) >= UNIT_COUNT)
                    begin
                        st_next    = bba_pkg::ST_BAD_FREE;
                        state_next = S_DONE;
                    end
                    else
                    begin
                        unit_next  = UNIT_W'(div_rsp.quot);
                        state_next = S_F_RD;
                    end
                end
            end
            S_F_RD:
            begin
                ao_re      = 1'b1;
                ao_raddr   = unit_reg;
                state_next = S_F_CHK;
            end
            S_F_CHK:
            begin
                if (ao_rdata == '0 || int'(ao_k) > TOP_ORDER)
                begin
                    st_next    = bba_pkg::ST_BAD_FREE;
                    state_next = S_DONE;
                end
                else
                begin
                    ao_we      = 1'b1;
                    ao_waddr   = unit_reg;
                    order_next = OW'(ao_k);
                    idx_next   = IW'(unit_reg) >> ao_k;
                    blk_next   = blk_reg - BLK_W'(1);
                    byt_next   = byt_reg - BYT_W'((SZ_W'(MIN_BLOCK_BYTES) << ao_k)
                                                  - SZ_W'(HEADER_BYTES));
                    state_next = S_F_BUD;
                end
            end
            S_F_BUD:
            begin
                if (order_reg == OW'(TOP_ORDER))
                    state_next = S_F_SRD;
                else
                begin
                    map_re     = 1'b1;
                    map_raddr  = wb_cur + MW_W'(bud_idx >> WSEL);
                    state_next = S_F_BCHK;
                end
            end
            S_F_BCHK:
            begin
                // merge with the buddy while it is free
                if (map_rdata[bud_idx[WSEL-1:0]])
                begin
                    map_we    = 1'b1;
                    map_waddr = wb_cur + MW_W'(bud_idx >> WSEL);
                    map_wdata = map_rdata & ~(WORD_W'(1) << bud_idx[WSEL-1:0]);
                    cnt_next[order_reg] = cnt_reg[order_reg] - CNT_W'(1);
                    idx_next   = idx_reg >> 1;
                    order_next = order_reg + OW'(1);
                    state_next = S_F_BUD;
                end
                else
                    state_next = S_F_SRD;
            end
            S_F_SRD:
            begin
                map_re     = 1'b1;
                map_raddr  = wb_cur + MW_W'(idx_reg >> WSEL);
                state_next = S_F_SWR;
            end
            S_F_SWR:
            begin
                map_we    = 1'b1;
                map_waddr = wb_cur + MW_W'(idx_reg >> WSEL);
                map_wdata = map_rdata | (WORD_W'(1) << idx_reg[WSEL-1:0]);
                cnt_next[order_reg] = cnt_reg[order_reg] + CNT_W'(1);
                st_next    = bba_pkg::ST_OK;
                state_next = S_DONE;
            end
            S_DONE:
            begin
                // hold until the output register is free
                if (!rsp_valid_reg || rsp.ready)
                begin
                    rsp_valid_next  = 1'b1;
                    rsp_status_next = st_reg;
                    rsp_pay_next    = pay_reg;
                    rsp_blk_next    = blk_reg;
                    rsp_byt_next    = byt_reg;
                    state_next      = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_CLEAR;
            clr_reg       <= '0;
            blk_reg       <= '0;
            byt_reg       <= '0;
            rsp_valid_reg <= 1'b0;
            for (int k = 0; k < ORDER_COUNT; k++)
                cnt_reg[k] <= (k == TOP_ORDER) ? CNT_W'(TOP_BLOCKS) : '0;
        end
        else
        begin
            state_reg     <= state_next;
            clr_reg       <= clr_next;
            blk_reg       <= blk_next;
            byt_reg       <= byt_next;
            rsp_valid_reg <= rsp_valid_next;
            cnt_reg       <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        order_reg      <= order_next;
        need_reg       <= need_next;
        idx_reg        <= idx_next;
        waddr_reg      <= waddr_next;
        unit_reg       <= unit_next;
        st_reg         <= st_next;
        pay_reg        <= pay_next;
        rsp_status_reg <= rsp_status_next;
        rsp_pay_reg    <= rsp_pay_next;
        rsp_blk_reg    <= rsp_blk_next;
        rsp_byt_reg    <= rsp_byt_next;
    end

    always_ff @(posedge clk)
    begin
        if (map_we)
            map_mem[map_waddr] <= map_wdata;
        if (map_re)
            map_rdata <= map_mem[map_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (ao_we)
            ao_mem[ao_waddr] <= ao_wdata;
        if (ao_re)
            ao_rdata <= ao_mem[ao_raddr];
    end

    assign req.ready          = (state_reg == S_IDLE);
    assign rsp.valid          = rsp_valid_reg;
    assign rsp.status         = rsp_status_reg;
    assign rsp.payload_offset = rsp_pay_reg;
    assign rsp.used_blocks    = rsp_blk_reg;
    assign rsp.used_bytes     = rsp_byt_reg;

    a_scan_nonempty: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A_RD |-> cnt_reg[order_reg] != '0)
        else $error("bitmap scan on an order with no free block");

    a_div_owner: assert property (@(posedge clk) disable iff (!rst_n)
        div_rsp.done |-> state_reg == S_F_DIV)
        else $error("divider finished outside a free");

    a_count_source: assert property (@(posedge clk) disable iff (!rst_n)
        blk_reg != $past(blk_reg) |->
            $past(state_reg) == S_A_FIN || $past(state_reg) == S_F_CHK)
        else $error("block count moved outside grant or release");

    a_map_port: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_A_SWR || state_reg == S_F_SWR |-> $past(map_re))
        else $error("bitmap write without the preceding read");

endmodule
